// ===== src/ctp_pkg.sv =====
// Shared types, constants and a helper function for the cartesian-to-polar pipeline.
package ctp_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int ITERATIONS  = 16;
    localparam int GUARD_BITS  = 16;

    // Datapath width for x and y: scaled input plus CORDIC growth and sign
    localparam int XY_W = (COORD_WIDTH + GUARD_BITS + 3 > 34) ?
                          (COORD_WIDTH + GUARD_BITS + 3) : 34;
    // Upper slice of the magnitude above the low 32 bits
    localparam int HI_W  = XY_W - 33;
    localparam int SUM_W = XY_W + 1;

    localparam int ATAN_IDX_W = 5;

    localparam logic [31:0] GAIN_INV_Q32  = 32'd2608131496;
    localparam logic [31:0] TURN_ZERO     = 32'h0000_0000;
    localparam logic [31:0] TURN_QUARTER  = 32'h4000_0000;
    localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
    localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;

    localparam int          ANG_SH   = 32 - ANGLE_WIDTH;
    localparam logic [31:0] ANG_HALF = (32'd1 << ANG_SH) >> 1;
    localparam logic [SUM_W-1:0] MAG_HALF = SUM_W'(1) << (GUARD_BITS - 1);

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
    } point_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] magnitude;
        logic [ANGLE_WIDTH-1:0] angle;
    } polar_t;

    // Working state carried down the rotation stages
    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic [31:0]             z;
        logic                    special;
        logic [COORD_WIDTH-1:0]  sp_mag;
        logic [ANGLE_WIDTH-1:0]  sp_angle;
    } rot_t;

    // Round a 32-bit turn fraction half up to ANGLE_WIDTH bits, wrapping
    function automatic logic [ANGLE_WIDTH-1:0] round_turn(input logic [31:0] turn);
        logic [31:0] sum;
        sum = turn + ANG_HALF;
        return sum[31 -: ANGLE_WIDTH];
    endfunction

endpackage

// ===== src/cartesian_to_polar_unit.sv =====
// Top level: pipelined CORDIC vectoring converter from (x, y) to magnitude and angle.
//
//   channel  | signals                              | direction | payload
//   ---------+--------------------------------------+-----------+-------------------------
//   request  | point_valid, point_ready, point      | in        | coord_x, coord_y
//   result   | polar_valid, polar_ready, polar      | out       | magnitude, angle
//
// One request per cycle is accepted while point_ready is high. A request passes
// ITERATIONS + 4 register stages (one fold stage, one per micro-rotation, two
// gain/rounding stages, the output register) before its result is presented.
// rst_n clears every valid bit; data registers are not reset. On a result stall the
// output register and its skid entry hold two results; when the skid entry fills,
// point_ready drops and the whole pipeline holds in place.
module cartesian_to_polar_unit
    import ctp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   point_valid,
    output logic   point_ready,
    input  point_t point,
    output logic   polar_valid,
    input  logic   polar_ready,
    output polar_t polar
);

    logic   en;
    logic   rot_valid [ITERATIONS+1];
    rot_t   rot_data  [ITERATIONS+1];
    logic   post_valid;
    polar_t post_data;

    assign point_ready = en;

    // Fold and classify
    ctp_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .point_valid (point_valid),
        .point       (point),
        .stage_valid (rot_valid[0]),
        .stage       (rot_data[0])
    );

    // Micro-rotation chain
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_rot
        ctp_rot u_rot (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (en),
            .idx         (ATAN_IDX_W'(i)),
            .prev_valid  (rot_valid[i]),
            .prev        (rot_data[i]),
            .stage_valid (rot_valid[i+1]),
            .stage       (rot_data[i+1])
        );
    end

    // Gain correction and rounding
    ctp_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .prev_valid   (rot_valid[ITERATIONS]),
        .prev         (rot_data[ITERATIONS]),
        .result_valid (post_valid),
        .result       (post_data)
    );

    // Output buffer, source of the pipeline advance enable
    ctp_skid u_skid (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (post_valid),
        .up_data     (post_data),
        .up_ready    (en),
        .polar_valid (polar_valid),
        .polar_ready (polar_ready),
        .polar       (polar)
    );

endmodule

// ===== src/ctp_prep.sv =====
// Input stage: axis/origin classification, left-half-plane fold and scaling.
module ctp_prep
    import ctp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   point_valid,
    input  point_t point,
    output logic   stage_valid,
    output rot_t   stage
);

    logic        valid_reg;
    rot_t        data_reg;
    rot_t        data_next;

    logic signed [XY_W-1:0]   x_ext;
    logic signed [XY_W-1:0]   y_ext;
    logic [COORD_WIDTH-1:0]   abs_x;
    logic [COORD_WIDTH-1:0]   abs_y;
    logic                     x_neg;
    logic                     y_neg;

    // Sign extension and absolute values
    always_comb
    begin
        x_neg = point.coord_x[COORD_WIDTH-1];
        y_neg = point.coord_y[COORD_WIDTH-1];
        x_ext = {{(XY_W-COORD_WIDTH){x_neg}}, point.coord_x};
        y_ext = {{(XY_W-COORD_WIDTH){y_neg}}, point.coord_y};
        abs_x = x_neg ? (~point.coord_x + 1'b1) : point.coord_x;
        abs_y = y_neg ? (~point.coord_y + 1'b1) : point.coord_y;
    end

    // Fold into the right half plane, scale, and precompute axis results
    always_comb
    begin
        if (x_neg)
        begin
            data_next.x = (-x_ext) <<< GUARD_BITS;
            data_next.y = (-y_ext) <<< GUARD_BITS;
            data_next.z = TURN_HALF;
        end
        else
        begin
            data_next.x = x_ext <<< GUARD_BITS;
            data_next.y = y_ext <<< GUARD_BITS;
            data_next.z = TURN_ZERO;
        end

        priority if (point.coord_x == '0 && point.coord_y == '0)
        begin
            data_next.special  = 1'b1;
            data_next.sp_mag   = '0;
            data_next.sp_angle = '0;
        end
        else if (point.coord_y == '0)
        begin
            data_next.special  = 1'b1;
            data_next.sp_mag   = abs_x;
            data_next.sp_angle = round_turn(x_neg ? TURN_HALF : TURN_ZERO);
        end
        else if (point.coord_x == '0)
        begin
            data_next.special  = 1'b1;
            data_next.sp_mag   = abs_y;
            data_next.sp_angle = round_turn(y_neg ? TURN_3QUARTER : TURN_QUARTER);
        end
        else
        begin
            data_next.special  = 1'b0;
            data_next.sp_mag   = '0;
            data_next.sp_angle = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= point_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = data_reg;

endmodule

// ===== src/ctp_rot.sv =====
// One CORDIC vectoring micro-rotation with its pipeline register.
module ctp_rot
    import ctp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [ATAN_IDX_W-1:0] idx,
    input  logic                  prev_valid,
    input  rot_t                  prev,
    output logic                  stage_valid,
    output rot_t                  stage
);

    logic        valid_reg;
    rot_t        data_reg;
    rot_t        data_next;

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    // Rotate toward y = 0 and accumulate the angle
    always_comb
    begin
        dx = prev.y >>> idx;
        dy = prev.x >>> idx;
        data_next = prev;
        if (prev.y > 0)
        begin
            data_next.x = prev.x + dx;
            data_next.y = prev.y - dy;
            data_next.z = prev.z + ATAN_TURNS[idx];
        end
        else
        begin
            data_next.x = prev.x - dx;
            data_next.y = prev.y + dy;
            data_next.z = prev.z - ATAN_TURNS[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = data_reg;

endmodule

// ===== src/ctp_post.sv =====
// Gain correction, magnitude rounding/saturation and angle rounding (two stages).
module ctp_post
    import ctp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   prev_valid,
    input  rot_t   prev,
    output logic   result_valid,
    output polar_t result
);

    logic [XY_W-2:0]        ux;
    logic [HI_W-1:0]        ux_hi;
    logic [31:0]            ux_lo;
    logic [63:0]            lo_prod;

    // Stage A registers: partial products and rounded angle
    logic                   a_valid_reg;
    logic [XY_W-2:0]        a_hi_prod_reg;
    logic [31:0]            a_lo_prod_reg;
    logic [ANGLE_WIDTH-1:0] a_angle_reg;
    logic                   a_special_reg;
    logic [COORD_WIDTH-1:0] a_sp_mag_reg;
    logic [ANGLE_WIDTH-1:0] a_sp_angle_reg;

    // Stage B
    logic [SUM_W-1:0]       mag_sum;
    logic [COORD_WIDTH-1:0] mag_sat;
    logic                   b_valid_reg;
    polar_t                 b_data_reg;
    polar_t                 b_data_next;

    // Split the clamped magnitude for the 1/K product
    always_comb
    begin
        ux      = (prev.x > 0) ? prev.x[XY_W-2:0] : '0;
        ux_hi   = ux[XY_W-2:32];
        ux_lo   = ux[31:0];
        lo_prod = ux_lo * GAIN_INV_Q32;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_hi_prod_reg  <= (XY_W-1)'(ux_hi * GAIN_INV_Q32);
            a_lo_prod_reg  <= lo_prod[63:32];
            a_angle_reg    <= round_turn(prev.z);
            a_special_reg  <= prev.special;
            a_sp_mag_reg   <= prev.sp_mag;
            a_sp_angle_reg <= prev.sp_angle;
        end
    end

    // Sum partial products, round to integer and saturate
    always_comb
    begin
        mag_sum = SUM_W'(a_hi_prod_reg) + SUM_W'(a_lo_prod_reg) + MAG_HALF;
        if (|mag_sum[SUM_W-1:GUARD_BITS+COORD_WIDTH])
        begin
            mag_sat = '1;
        end
        else
        begin
            mag_sat = mag_sum[GUARD_BITS+COORD_WIDTH-1:GUARD_BITS];
        end

        if (a_special_reg)
        begin
            b_data_next.magnitude = a_sp_mag_reg;
            b_data_next.angle     = a_sp_angle_reg;
        end
        else
        begin
            b_data_next.magnitude = mag_sat;
            b_data_next.angle     = a_angle_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_data_reg <= b_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= prev_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    assign result_valid = b_valid_reg;
    assign result       = b_data_reg;

endmodule

// ===== src/ctp_skid.sv =====
// Output register with skid entry; its ready is registered and stalls the pipeline.
module ctp_skid
    import ctp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    input  polar_t up_data,
    output logic   up_ready,
    output logic   polar_valid,
    input  logic   polar_ready,
    output polar_t polar
);

    logic   out_valid_reg;
    polar_t out_data_reg;
    logic   skid_valid_reg;
    polar_t skid_data_reg;
    logic   up_fire;

    assign up_ready = !skid_valid_reg;
    assign up_fire  = up_valid && up_ready;

    // Control: output slot drains first from skid, then from upstream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (polar_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= up_fire;
            end
        end
        else if (up_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (polar_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (up_fire)
            begin
                out_data_reg <= up_data;
            end
        end
        else if (up_fire)
        begin
            skid_data_reg <= up_data;
        end
    end

    assign polar_valid = out_valid_reg;
    assign polar       = out_data_reg;

endmodule

// ===== verif/polar_checker.sv =====
// Checker for the cartesian-to-polar unit: predicts each result and compares in order.
`timescale 1ns / 100ps

module polar_checker
    import ctp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   point_valid,
    input  logic   point_ready,
    input  point_t point,
    input  logic   polar_valid,
    input  logic   polar_ready,
    input  polar_t polar,
    output int     error_count,
    output int     outstanding
);

    localparam int                FRAC_BITS    = 16;
    localparam longint unsigned   INV_GAIN_Q32 = 64'd2608131496;
    localparam longint unsigned   ANGLE_HALF   = (64'd1 << (32 - ANGLE_WIDTH)) >> 1;
    localparam longint unsigned   MAG_MAX      = (64'd1 << COORD_WIDTH) - 64'd1;
    localparam logic [31:0]       HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0]       QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0]       THREEQ_TURN  = 32'hC000_0000;

    // atan(2^-i) as a fraction of a full turn, 2^-32 units
    localparam logic [31:0] ATAN_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct {
        point_t req;
        polar_t res;
    } pending_polar_t;

    pending_polar_t expected_q [$];
    int             fail_total;

    // Vectoring CORDIC: fold into the right half plane, rotate y to zero, remove gain
    function automatic polar_t predict_polar(input point_t p);
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint unsigned ux;
        longint unsigned prod;
        longint unsigned mag_wide;
        longint unsigned angle_sum;
        logic [31:0]     turn;
        int              i;
        polar_t          r;
        x = longint'($signed(p.coord_x));
        y = longint'($signed(p.coord_y));
        turn = '0;
        if (x == 0 && y == 0) begin
            mag_wide = 0;
        end
        else if (y == 0) begin
            mag_wide = (x > 0) ? x : -x;
            turn = (x > 0) ? 32'h0 : HALF_TURN;
        end
        else if (x == 0) begin
            mag_wide = (y > 0) ? y : -y;
            turn = (y > 0) ? QUARTER_TURN : THREEQ_TURN;
        end
        else begin
            if (x < 0) begin
                x = -x;
                y = -y;
                turn = HALF_TURN;
            end
            x = x <<< FRAC_BITS;
            y = y <<< FRAC_BITS;
            z = 0;
            for (i = 0; i < ITERATIONS; i++) begin
                dx = y >>> (i & 31);
                dy = x >>> (i & 31);
                if (y > 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(ATAN_STEP[i & 31]);
                end
                else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(ATAN_STEP[i & 31]);
                end
            end
            ux = (x > 0) ? x : 0;
            // 64x32 product in two halves, floored to Q32
            prod = (ux >> 32) * INV_GAIN_Q32
                 + (((ux & 64'hFFFF_FFFF) * INV_GAIN_Q32) >> 32);
            mag_wide = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            turn = turn + z[31:0];
        end
        r.magnitude = (mag_wide > MAG_MAX) ? MAG_MAX[COORD_WIDTH-1:0]
                                           : mag_wide[COORD_WIDTH-1:0];
        // round half up to the angle width; a full turn wraps to zero
        angle_sum = {32'd0, turn} + ANGLE_HALF;
        r.angle = angle_sum[31 -: ANGLE_WIDTH];
        return r;
    endfunction

    // Queue expectations on accepted requests, compare on accepted results
    always @(posedge clk) begin
        pending_polar_t entry;
        if (!rst_n) begin
            expected_q.delete();
            fail_total = 0;
        end
        else begin
            if (point_valid && point_ready) begin
                entry.req = point;
                entry.res = predict_polar(point);
                expected_q.push_back(entry);
            end
            if (polar_valid && polar_ready) begin
                if (expected_q.size() == 0) begin
                    if (fail_total < 10)
                        $display("%0t: result mag=%0d ang=%0d with no pending request",
                                 $realtime, polar.magnitude, polar.angle);
                    fail_total++;
                end
                else begin
                    entry = expected_q.pop_front();
                    if (polar.magnitude !== entry.res.magnitude ||
                        polar.angle !== entry.res.angle) begin
                        if (fail_total < 10)
                            $display("%0t: point (%0d,%0d) expected mag=%0d ang=%0d, got mag=%0d ang=%0d",
                                     $realtime, $signed(entry.req.coord_x),
                                     $signed(entry.req.coord_y), entry.res.magnitude,
                                     entry.res.angle, polar.magnitude, polar.angle);
                        fail_total++;
                    end
                end
            end
        end
        error_count <= fail_total;
        outstanding <= expected_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top: drives points into the cartesian-to-polar unit and reports the verdict.
`timescale 1ns / 100ps

module tb_top;
    import ctp_pkg::*;

    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MAX = ~COORD_MIN;
    localparam int NUM_RANDOM = 1450;

    // axes, corners, unit steps and angles that round to a full turn
    localparam int DIR_X [20] = '{0, 32767, -32768, 0, 0, 32767, -32768, -32768, 32767, 1,
                                  -1, 1, -1, 1, -1, 0, 0, 32767, -32768, -32768};
    localparam int DIR_Y [20] = '{0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768, 1,
                                  -1, -1, 1, 0, 0, 1, -1, -1, 1, -1};

    logic   clk;
    logic   rst_n;
    logic   point_valid;
    logic   point_ready;
    point_t point;
    logic   polar_valid;
    logic   polar_ready;
    polar_t polar;
    int     error_count;
    int     outstanding;
    bit     send_idle;
    bit     recv_idle;

    cartesian_to_polar_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .polar_valid (polar_valid),
        .polar_ready (polar_ready),
        .polar       (polar)
    );

    polar_checker u_polar_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .polar_valid (polar_valid),
        .polar_ready (polar_ready),
        .polar       (polar),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Present one request and hold it until the unit takes it
    task automatic send_point(input point_t p);
        point       <= p;
        point_valid <= 1'b1;
        @(posedge clk);
        while (!point_ready) @(posedge clk);
    endtask

    // Hold off until every queued request has produced its result
    task automatic drain_results();
        point_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Result side back-pressure in bursts
    initial
    begin
        polar_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (recv_idle && $urandom_range(0, 4) == 0)
            begin
                polar_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            polar_ready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        point_t p;
        int     k;
        int     sel;
        rst_n       = 1'b0;
        point_valid = 1'b0;
        point       = '0;
        send_idle   = 1'b0;
        recv_idle   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // axes, corners, unit steps and angles that round to a full turn
        for (k = 0; k < 20; k++)
        begin
            p.coord_x = COORD_WIDTH'(DIR_X[k]);
            p.coord_y = COORD_WIDTH'(DIR_Y[k]);
            send_point(p);
        end
        drain_results();

        for (k = 0; k < NUM_RANDOM; k++)
        begin
            // idling mix changes per phase; the final phase runs flat out
            case (k / 250)
                0, 4:
                begin
                    send_idle = 1'b1;
                    recv_idle = 1'b1;
                end
                1:
                begin
                    send_idle = 1'b1;
                    recv_idle = 1'b0;
                end
                3:
                begin
                    send_idle = 1'b0;
                    recv_idle = 1'b1;
                end
                default:
                begin
                    send_idle = 1'b0;
                    recv_idle = 1'b0;
                end
            endcase
            if (k == 725)
                drain_results();

            p.coord_x = COORD_WIDTH'($urandom);
            p.coord_y = COORD_WIDTH'($urandom);
            sel = $urandom_range(0, 9);
            case (sel)
                // tiny vectors, where rounding dominates
                0, 1:
                begin
                    p.coord_x = COORD_WIDTH'(int'($urandom_range(0, 16)) - 8);
                    p.coord_y = COORD_WIDTH'(int'($urandom_range(0, 16)) - 8);
                end
                // exactly on an axis
                2:
                begin
                    if ($urandom_range(0, 1))
                        p.coord_x = '0;
                    else
                        p.coord_y = '0;
                end
                // range limits on one or both coordinates
                3:
                begin
                    p.coord_x = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
                    if ($urandom_range(0, 1))
                        p.coord_y = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
                end
                // just off the x axis, angle near zero or a half turn
                4: p.coord_y = COORD_WIDTH'(int'($urandom_range(0, 6)) - 3);
                // just off the y axis
                5: p.coord_x = COORD_WIDTH'(int'($urandom_range(0, 6)) - 3);
                default: ;
            endcase

            if (send_idle && $urandom_range(0, 3) == 0)
            begin
                point_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            send_point(p);
        end

        recv_idle = 1'b0;
        drain_results();
        repeat (40) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
